// ===== design/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types and codes for the binary heap priority queue: command and
// status codes, the transaction structs and the sequencer states.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] push_priority;
    logic [31:0]        push_payload;
  } bhpq_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_priority;
    logic [31:0]        popped_payload;
    logic [10:0]        entry_count;
    logic               top_valid;
    logic signed [31:0] top_priority;
    logic [31:0]        top_payload;
  } bhpq_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_e;

endpackage

// ===== design/bhpq_ram.sv =====
// ----------------------------------------------------------------------------
// bhpq_ram
// Heap entry storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a_q;
  logic [DW-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/binary_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Min- or max-heap priority queue held in one synchronous RAM; push sifts up,
// pop sifts down, with a read and then a compare-and-write per heap level.
// Clear, unused codes and errors go straight to the result strobe. Push climbs
// from the new leaf; pop first reads the last entry (S_LAST), ends there if the
// heap is now empty, else sifts it down from the root. A new transaction is
// taken only in idle, after the result strobe; the receiver cannot stall
// results. Reset clears count, order and sequencer, not the RAM.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
  parameter int unsigned CAPACITY       = 1024,
  parameter int unsigned PRIORITY_WIDTH = 32,
  parameter int unsigned PAYLOAD_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bhpq_pkg::bhpq_in_t  cmd_i,
  output logic                res_valid_o,
  output bhpq_pkg::bhpq_out_t res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  import bhpq_pkg::*;

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned KW    = PRIORITY_WIDTH;
  localparam int unsigned EW    = PRIORITY_WIDTH + PAYLOAD_WIDTH;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [EW-1:0]    ent_q, ent_d;
  logic [EW-1:0]    popped_q, popped_d;
  status_e          status_q, status_d;
  logic [EW-1:0]    top_q;
  logic             order_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [EW-1:0]    mem_wdata;
  logic [AW-1:0]    rd_a_addr;
  logic [AW-1:0]    rd_b_addr;
  logic [EW-1:0]    rd_a_data;
  logic [EW-1:0]    rd_b_data;

  logic [CNT_W:0]   lchild;
  logic [CNT_W:0]   rchild;
  logic [CNT_W:0]   cnt_ext;
  logic [CNT_W:0]   pos_ext;
  logic [EW-1:0]    new_ent;
  logic [EW-1:0]    child_ent;
  logic             pick_right;
  logic [31:0]      cnt_wide;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W:0] p);
    logic [CNT_W:0] t;
    t = p - (CNT_W+1)'(1);
    return t[AW-1:0];
  endfunction

  function automatic logic signed [KW-1:0] key_of(input logic [EW-1:0] e);
    return $signed(e[EW-1 -: KW]);
  endfunction

  function automatic logic better(input logic [EW-1:0] a, input logic [EW-1:0] b,
                                  input logic ord);
    logic signed [KW-1:0] ka;
    logic signed [KW-1:0] kb;
    ka = key_of(a);
    kb = key_of(b);
    return ord ? (ka > kb) : (ka < kb);
  endfunction

  bhpq_ram #(
    .DEPTH (CAPACITY),
    .DW    (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (rd_a_addr),
    .raddr_b_i (rd_b_addr),
    .rdata_a_o (rd_a_data),
    .rdata_b_o (rd_b_data)
  );

  assign pos_ext    = {1'b0, pos_q};
  assign cnt_ext    = {1'b0, count_q};
  assign lchild     = {pos_q, 1'b0};
  assign rchild     = lchild + (CNT_W+1)'(1);
  assign new_ent    = {cmd_i.push_priority[KW-1:0], cmd_i.push_payload[PAYLOAD_WIDTH-1:0]};
  assign pick_right = (rchild <= cnt_ext) && !better(rd_a_data, rd_b_data, order_q);
  assign child_ent  = pick_right ? rd_b_data : rd_a_data;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    ent_d     = ent_q;
    popped_d  = popped_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = addr_of(pos_ext);
    mem_wdata = ent_q;
    rd_a_addr = addr_of(lchild);
    rd_b_addr = addr_of(rchild);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          popped_d = '0;
          status_d = STAT_OK;
          state_d  = S_RESP;
          unique case (cmd_i.command)
            CMD_PUSH: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
                pos_d   = count_q + CNT_W'(1);
                ent_d   = new_ent;
                state_d = S_UP_RD;
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                popped_d  = top_q;
                rd_a_addr = addr_of(cnt_ext);
                count_d   = count_q - CNT_W'(1);
                state_d   = S_LAST;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_LAST: begin
        ent_d = rd_a_data;
        pos_d = CNT_W'(1);
        state_d = (count_q == '0) ? S_RESP : S_DN_RD;
      end
      S_UP_RD: begin
        rd_a_addr = addr_of(pos_ext >> 1);
        if (pos_q == CNT_W'(1)) begin
          mem_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (better(ent_q, rd_a_data, order_q)) begin
          mem_wdata = rd_a_data;
          pos_d     = pos_q >> 1;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_DN_RD: begin
        if (lchild > cnt_ext) begin
          mem_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (better(child_ent, ent_q, order_q)) begin
          mem_wdata = child_ent;
          pos_d     = pick_right ? rchild[CNT_W-1:0] : lchild[CNT_W-1:0];
          state_d   = S_DN_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      order_q  <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    ent_q    <= ent_d;
    popped_q <= popped_d;
    if (mem_we && (mem_waddr == '0)) begin
      top_q <= mem_wdata;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = (state_q == S_RESP);
  assign cnt_wide    = 32'(count_q);

  always_comb begin
    res_o                 = '0;
    res_o.status          = status_q;
    res_o.popped_priority = 32'(key_of(popped_q));
    res_o.popped_payload  = 32'(popped_q[PAYLOAD_WIDTH-1:0]);
    res_o.entry_count     = cnt_wide[10:0];
    res_o.top_valid       = (count_q != '0);
    if (count_q != '0) begin
      res_o.top_priority = 32'(key_of(top_q));
      res_o.top_payload  = 32'(top_q[PAYLOAD_WIDTH-1:0]);
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((pos_q != '0) && (pos_q <= count_q)))
    else $error("heap write outside stored entries");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> $stable(count_q))
    else $error("entry count changed mid transaction");

endmodule
